>>> hw/rtl/keyframe_interpolator_assert.svh
// Assertion macros shared by the modules of the keyframe interpolator.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef KEYFRAME_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KFI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KFI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/kfi_pkg.sv
package kfi_pkg;

    localparam int KEY_DEPTH   = 16;
    localparam int EVENT_DEPTH = 16;
    localparam int KEY_IDX_W   = $clog2(KEY_DEPTH);
    localparam int KEY_CNT_W   = $clog2(KEY_DEPTH + 1);
    localparam int EV_IDX_W    = $clog2(EVENT_DEPTH);
    localparam int EV_CNT_W    = $clog2(EVENT_DEPTH + 1);

    localparam int FUNC_W   = 3;
    localparam int MS_W     = 16;
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 32;
    localparam int SPEED_W  = 16;
    localparam int STAT_W   = 2;
    localparam int CLK_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int FRAC_W   = 17;

    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 33;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADDK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ADDE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLRK  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLRE  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DIS  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = 2'd2;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } div_rsp_t;

endpackage

>>> hw/rtl/kfi_serdiv.sv
module kfi_serdiv (
    input  logic              clk,
    input  logic              rst_n,
    input  kfi_pkg::div_req_t req,
    output kfi_pkg::div_rsp_t rsp
);
    import kfi_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   dq_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     trial_sub;
    logic                 ge;
    logic [DIV_D_W-1:0]   rem_next;

    // One quotient bit is settled in each cycle by a restoring step.
    always_comb
    begin
        trial     = {rem_reg, dq_reg[DIV_N_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        rem_next  = ge ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DIV_N_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> hw/rtl/keyframe_interpolator.sv
// Channel   Handshake              Payload
// in        in_valid / in_stall    func, elapsed_ms, entry_time, entry_value
// out       out_valid / out_stall  status, clock_now, value, value_valid,
//                                  key_index, key_changed, event_index, event_fired
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is worked on at a time; a clear acts on acceptance, an add first scans its
// table for the insert point, and a tick steps through the advance and the scans.
// A tick uses the bit-serial divider for the loop wrap and for the fraction, and scans
// the key and event tables one entry per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset is asynchronous; the tables need no clearing pass, as only filled entries are read.
module keyframe_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [kfi_pkg::FUNC_W-1:0]          func,
    input  logic [kfi_pkg::MS_W-1:0]            elapsed_ms,
    input  logic [kfi_pkg::TIME_W-1:0]          entry_time,
    input  logic signed [kfi_pkg::VAL_W-1:0]    entry_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [kfi_pkg::STAT_W-1:0]          status,
    output logic [kfi_pkg::CLK_W-1:0]           clock_now,
    output logic signed [kfi_pkg::VAL_W-1:0]    value,
    output logic                                value_valid,
    output logic [kfi_pkg::KEY_IDX_W-1:0]       key_index,
    output logic                                key_changed,
    output logic [kfi_pkg::EV_IDX_W-1:0]        event_index,
    output logic                                event_fired,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kfi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kfi_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import kfi_pkg::*;

    `include "keyframe_interpolator_assert.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_ADV    = 4'd2;
    localparam logic [3:0] S_MODW   = 4'd3;
    localparam logic [3:0] S_KSCAN  = 4'd4;
    localparam logic [3:0] S_KRD2   = 4'd5;
    localparam logic [3:0] S_KRD1   = 4'd6;
    localparam logic [3:0] S_KCALC  = 4'd7;
    localparam logic [3:0] S_DIVW   = 4'd8;
    localparam logic [3:0] S_KMUL   = 4'd9;
    localparam logic [3:0] S_KFLAG  = 4'd10;
    localparam logic [3:0] S_ESCAN  = 4'd11;
    localparam logic [3:0] S_KINS_S = 4'd12;
    localparam logic [3:0] S_EINS_S = 4'd13;
    localparam logic [3:0] S_INS    = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0]                state_reg;
    logic [FUNC_W-1:0]         func_reg;
    logic [MS_W-1:0]           ems_reg;
    logic [TIME_W-1:0]         etime_reg;
    logic signed [VAL_W-1:0]   evalue_reg;

    logic [TIME_W-1:0]         loop_len_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic                      enabled_reg;

    logic [TIME_W-1:0]         key_t_reg [KEY_DEPTH];
    logic signed [VAL_W-1:0]   key_v_reg [KEY_DEPTH];
    logic [TIME_W-1:0]         ev_t_reg [EVENT_DEPTH];
    logic [KEY_CNT_W-1:0]      key_cnt_reg;
    logic [EV_CNT_W-1:0]       ev_cnt_reg;
    logic [CLK_W-1:0]          key_clk_reg;
    logic [CLK_W-1:0]          ev_clk_reg;
    logic [KEY_IDX_W-1:0]      last_key_reg;
    logic                      last_key_vld_reg;
    logic [EV_IDX_W-1:0]       last_ev_reg;
    logic                      last_ev_vld_reg;

    logic [TIME_W-1:0]         delta_reg;
    logic [TIME_W-1:0]         t_reg;
    logic [KEY_CNT_W-1:0]      idx_reg;
    logic [EV_CNT_W-1:0]       eidx_reg;
    logic [KEY_IDX_W-1:0]      k1_reg;
    logic                      wrap_reg;
    logic [TIME_W-1:0]         t1_reg;
    logic [DIV_D_W-1:0]        t2_reg;
    logic signed [VAL_W-1:0]   v1_reg;
    logic signed [VAL_W-1:0]   v2_reg;
    logic signed [50:0]        prod_reg;
    div_req_t                  div_req_reg;
    div_rsp_t                  div_rsp;

    logic [STAT_W-1:0]         res_status_reg;
    logic signed [VAL_W-1:0]   res_value_reg;
    logic                      res_vvalid_reg;
    logic                      res_kchg_reg;
    logic [EV_IDX_W-1:0]       res_eidx_reg;
    logic                      res_efired_reg;

    logic                      out_valid_reg;
    logic [STAT_W-1:0]         status_reg;
    logic [CLK_W-1:0]          clock_now_reg;
    logic signed [VAL_W-1:0]   value_reg;
    logic                      value_valid_reg;
    logic [KEY_IDX_W-1:0]      key_index_reg;
    logic                      key_changed_reg;
    logic [EV_IDX_W-1:0]       event_index_reg;
    logic                      event_fired_reg;

    logic [CLK_W:0]            key_sum;
    logic [CLK_W:0]            ev_sum;
    logic [CLK_W-1:0]          key_sat;
    logic [CLK_W-1:0]          ev_sat;
    logic [TIME_W-1:0]         kt_rd;
    logic signed [VAL_W-1:0]   kv_rd;
    logic [TIME_W-1:0]         et_rd;
    logic [KEY_IDX_W-1:0]      k1_sel;
    logic [EV_IDX_W-1:0]       ev_sel;
    logic signed [DIV_D_W-1:0] vdiff;
    logic signed [FRAC_W:0]    frac_s;
    logic [TIME_W-1:0]         num;
    logic                      accept;
    logic                      out_load;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_sum = {1'b0, key_clk_reg} + {{(CLK_W + 1 - TIME_W){1'b0}}, delta_reg};
        ev_sum  = {1'b0, ev_clk_reg} + {{(CLK_W + 1 - TIME_W){1'b0}}, delta_reg};
        key_sat = key_sum[CLK_W] ? {CLK_W{1'b1}} : key_sum[CLK_W-1:0];
        ev_sat  = ev_sum[CLK_W] ? {CLK_W{1'b1}} : ev_sum[CLK_W-1:0];
        kt_rd   = key_t_reg[idx_reg[KEY_IDX_W-1:0]];
        kv_rd   = key_v_reg[idx_reg[KEY_IDX_W-1:0]];
        et_rd   = ev_t_reg[eidx_reg[EV_IDX_W-1:0]];
        if (idx_reg != '0 && t_reg < kt_rd)
        begin
            k1_sel = KEY_IDX_W'(idx_reg - 1'b1);
        end
        else
        begin
            k1_sel = idx_reg[KEY_IDX_W-1:0];
        end
        if (eidx_reg == ev_cnt_reg)
        begin
            ev_sel = EV_IDX_W'(ev_cnt_reg - 1'b1);
        end
        else if (eidx_reg != '0 && ev_clk_reg < {{(CLK_W - TIME_W){1'b0}}, et_rd})
        begin
            ev_sel = EV_IDX_W'(eidx_reg - 1'b1);
        end
        else
        begin
            ev_sel = eidx_reg[EV_IDX_W-1:0];
        end
        vdiff  = {v2_reg[VAL_W-1], v2_reg} - {v1_reg[VAL_W-1], v1_reg};
        frac_s = {1'b0, div_rsp.quotient[FRAC_W-1:0]};
        num    = t_reg - t1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            func_reg         <= '0;
            ems_reg          <= '0;
            etime_reg        <= '0;
            evalue_reg       <= '0;
            loop_len_reg     <= '0;
            speed_reg        <= SPEED_W'(256);
            enabled_reg      <= 1'b1;
            key_cnt_reg      <= '0;
            ev_cnt_reg       <= '0;
            key_clk_reg      <= '0;
            ev_clk_reg       <= '0;
            last_key_reg     <= '0;
            last_key_vld_reg <= 1'b0;
            last_ev_reg      <= '0;
            last_ev_vld_reg  <= 1'b0;
            delta_reg        <= '0;
            t_reg            <= '0;
            idx_reg          <= '0;
            eidx_reg         <= '0;
            k1_reg           <= '0;
            wrap_reg         <= 1'b0;
            t1_reg           <= '0;
            t2_reg           <= '0;
            v1_reg           <= '0;
            v2_reg           <= '0;
            prod_reg         <= '0;
            div_req_reg      <= '0;
            res_status_reg   <= STAT_OK;
            res_value_reg    <= '0;
            res_vvalid_reg   <= 1'b0;
            res_kchg_reg     <= 1'b0;
            res_eidx_reg     <= '0;
            res_efired_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            status_reg       <= STAT_OK;
            clock_now_reg    <= '0;
            value_reg        <= '0;
            value_valid_reg  <= 1'b0;
            key_index_reg    <= '0;
            key_changed_reg  <= 1'b0;
            event_index_reg  <= '0;
            event_fired_reg  <= 1'b0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_LOOP_LEN: loop_len_reg <= cfg_data;
                    REG_SPEED:    speed_reg    <= cfg_data[SPEED_W-1:0];
                    REG_ENABLED:  enabled_reg  <= cfg_data[0];
                    default:      ;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg       <= func;
                        ems_reg        <= elapsed_ms;
                        etime_reg      <= entry_time;
                        evalue_reg     <= entry_value;
                        res_status_reg <= STAT_OK;
                        res_value_reg  <= '0;
                        res_vvalid_reg <= 1'b0;
                        k1_reg         <= '0;
                        res_kchg_reg   <= 1'b0;
                        res_eidx_reg   <= '0;
                        res_efired_reg <= 1'b0;
                        idx_reg        <= '0;
                        eidx_reg       <= '0;
                        state_reg      <= S_DONE;
                        case (func)
                            FN_TICK:
                            begin
                                if (!enabled_reg)
                                begin
                                    res_status_reg <= STAT_DIS;
                                end
                                else
                                begin
                                    state_reg <= S_MUL;
                                end
                            end
                            FN_ADDK:
                            begin
                                if (key_cnt_reg >= KEY_CNT_W'(KEY_DEPTH))
                                begin
                                    res_status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    state_reg <= S_KINS_S;
                                end
                            end
                            FN_ADDE:
                            begin
                                if (ev_cnt_reg >= EV_CNT_W'(EVENT_DEPTH))
                                begin
                                    res_status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    state_reg <= S_EINS_S;
                                end
                            end
                            FN_CLRK:
                            begin
                                key_cnt_reg      <= '0;
                                last_key_reg     <= '0;
                                last_key_vld_reg <= 1'b0;
                            end
                            FN_CLRE:
                            begin
                                ev_cnt_reg      <= '0;
                                ev_clk_reg      <= '0;
                                last_ev_reg     <= '0;
                                last_ev_vld_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL:
                begin
                    delta_reg <= TIME_W'(ems_reg) * TIME_W'(speed_reg);
                    state_reg <= S_ADV;
                end
                S_ADV:
                begin
                    key_clk_reg <= key_sat;
                    ev_clk_reg  <= ev_sat;
                    if (loop_len_reg == '0)
                    begin
                        res_status_reg <= STAT_ZERO;
                        state_reg      <= S_ESCAN;
                    end
                    else if (key_cnt_reg == '0)
                    begin
                        state_reg <= S_ESCAN;
                    end
                    else if (key_sat > {{(CLK_W - TIME_W){1'b0}}, loop_len_reg})
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= key_sat - 1'b1;
                        div_req_reg.divisor  <= {1'b0, loop_len_reg};
                        state_reg            <= S_MODW;
                    end
                    else
                    begin
                        t_reg     <= key_sat[TIME_W-1:0];
                        state_reg <= S_KSCAN;
                    end
                end
                S_MODW:
                begin
                    if (div_rsp.done)
                    begin
                        t_reg     <= div_rsp.remainder[TIME_W-1:0] + 1'b1;
                        state_reg <= S_KSCAN;
                    end
                end
                S_KSCAN:
                begin
                    if (idx_reg == key_cnt_reg)
                    begin
                        k1_reg    <= KEY_IDX_W'(key_cnt_reg - 1'b1);
                        wrap_reg  <= 1'b1;
                        idx_reg   <= '0;
                        state_reg <= S_KRD2;
                    end
                    else if (kt_rd >= t_reg)
                    begin
                        k1_reg    <= k1_sel;
                        wrap_reg  <= 1'b0;
                        state_reg <= S_KRD2;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_KRD2:
                begin
                    t2_reg    <= wrap_reg ? {1'b0, loop_len_reg} + {1'b0, kt_rd}
                                          : {1'b0, kt_rd};
                    v2_reg    <= kv_rd;
                    idx_reg   <= {1'b0, k1_reg};
                    state_reg <= S_KRD1;
                end
                S_KRD1:
                begin
                    t1_reg    <= kt_rd;
                    v1_reg    <= kv_rd;
                    state_reg <= S_KCALC;
                end
                S_KCALC:
                begin
                    if (t2_reg == {1'b0, t1_reg} || t_reg < t1_reg)
                    begin
                        res_value_reg <= v1_reg;
                        state_reg     <= S_KFLAG;
                    end
                    else
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= {num, 16'b0};
                        div_req_reg.divisor  <= t2_reg - {1'b0, t1_reg};
                        state_reg            <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_rsp.done)
                    begin
                        prod_reg  <= vdiff * frac_s;
                        state_reg <= S_KMUL;
                    end
                end
                S_KMUL:
                begin
                    res_value_reg <= v1_reg + $signed(prod_reg[47:16]);
                    state_reg     <= S_KFLAG;
                end
                S_KFLAG:
                begin
                    res_vvalid_reg <= 1'b1;
                    if (!last_key_vld_reg || last_key_reg != k1_reg)
                    begin
                        res_kchg_reg     <= 1'b1;
                        last_key_reg     <= k1_reg;
                        last_key_vld_reg <= 1'b1;
                    end
                    state_reg <= S_ESCAN;
                end
                S_ESCAN:
                begin
                    if (ev_cnt_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (eidx_reg == ev_cnt_reg
                             || {{(CLK_W - TIME_W){1'b0}}, et_rd} >= ev_clk_reg)
                    begin
                        res_eidx_reg <= ev_sel;
                        if (!last_ev_vld_reg || last_ev_reg != ev_sel)
                        begin
                            res_efired_reg  <= 1'b1;
                            last_ev_reg     <= ev_sel;
                            last_ev_vld_reg <= 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        eidx_reg <= eidx_reg + 1'b1;
                    end
                end
                S_KINS_S:
                begin
                    if (idx_reg == key_cnt_reg || kt_rd > etime_reg)
                    begin
                        state_reg <= S_INS;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_EINS_S:
                begin
                    if (eidx_reg == ev_cnt_reg || et_rd > etime_reg)
                    begin
                        state_reg <= S_INS;
                    end
                    else
                    begin
                        eidx_reg <= eidx_reg + 1'b1;
                    end
                end
                S_INS:
                begin
                    if (func_reg == FN_ADDK)
                    begin
                        key_cnt_reg <= key_cnt_reg + 1'b1;
                        if (last_key_vld_reg && idx_reg <= {1'b0, last_key_reg})
                        begin
                            last_key_reg <= last_key_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ev_cnt_reg <= ev_cnt_reg + 1'b1;
                        if (last_ev_vld_reg && eidx_reg <= {1'b0, last_ev_reg})
                        begin
                            last_ev_reg <= last_ev_reg + 1'b1;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= res_status_reg;
                        clock_now_reg   <= key_clk_reg;
                        value_reg       <= res_value_reg;
                        value_valid_reg <= res_vvalid_reg;
                        key_index_reg   <= res_vvalid_reg ? k1_reg : '0;
                        key_changed_reg <= res_kchg_reg;
                        event_index_reg <= res_eidx_reg;
                        event_fired_reg <= res_efired_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Insertion shifts every entry above the insert point up by one place.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INS && func_reg == FN_ADDK)
        begin
            for (int j = 1; j < KEY_DEPTH; j++)
            begin
                if (KEY_CNT_W'(j) > idx_reg)
                begin
                    key_t_reg[j] <= key_t_reg[j-1];
                    key_v_reg[j] <= key_v_reg[j-1];
                end
            end
            key_t_reg[idx_reg[KEY_IDX_W-1:0]] <= etime_reg;
            key_v_reg[idx_reg[KEY_IDX_W-1:0]] <= evalue_reg;
        end
        if (state_reg == S_INS && func_reg == FN_ADDE)
        begin
            for (int j = 1; j < EVENT_DEPTH; j++)
            begin
                if (EV_CNT_W'(j) > eidx_reg)
                begin
                    ev_t_reg[j] <= ev_t_reg[j-1];
                end
            end
            ev_t_reg[eidx_reg[EV_IDX_W-1:0]] <= etime_reg;
        end
    end

    kfi_serdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign clock_now   = clock_now_reg;
    assign value       = value_reg;
    assign value_valid = value_valid_reg;
    assign key_index   = key_index_reg;
    assign key_changed = key_changed_reg;
    assign event_index = event_index_reg;
    assign event_fired = event_fired_reg;

    `KFI_ASSERT_NXT(a_busy_after_accept, accept, in_stall, "accepted item did not start work")
    `KFI_ASSERT_IMP(a_key_cnt_range, 1'b1, key_cnt_reg <= KEY_CNT_W'(KEY_DEPTH),
        "keyframe count beyond table depth")
    `KFI_ASSERT_IMP(a_last_key_in_table, last_key_vld_reg,
        {1'b0, last_key_reg} < key_cnt_reg, "remembered keyframe outside the table")
    `KFI_ASSERT_IMP(a_div_done_expected, div_rsp.done,
        state_reg == S_MODW || state_reg == S_DIVW, "divider finished while not awaited")

endmodule

>>> tb/kfi_checker.sv
module kfi_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [kfi_pkg::FUNC_W-1:0]        func,
    input  logic [kfi_pkg::MS_W-1:0]          elapsed_ms,
    input  logic [kfi_pkg::TIME_W-1:0]        entry_time,
    input  logic signed [kfi_pkg::VAL_W-1:0]  entry_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [kfi_pkg::STAT_W-1:0]        status,
    input  logic [kfi_pkg::CLK_W-1:0]         clock_now,
    input  logic signed [kfi_pkg::VAL_W-1:0]  value,
    input  logic                              value_valid,
    input  logic [kfi_pkg::KEY_IDX_W-1:0]     key_index,
    input  logic                              key_changed,
    input  logic [kfi_pkg::EV_IDX_W-1:0]      event_index,
    input  logic                              event_fired,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [kfi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kfi_pkg::CFG_DAT_W-1:0]     cfg_data,
    output int                                mismatches,
    output int                                awaiting
);
    import kfi_pkg::*;

    localparam longint unsigned CLOCK_SAT = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [CLK_W-1:0]        clock_now;
        logic signed [VAL_W-1:0] value;
        logic                    value_valid;
        logic [KEY_IDX_W-1:0]    key_index;
        logic                    key_changed;
        logic [EV_IDX_W-1:0]     event_index;
        logic                    event_fired;
    } frame_result_t;

    frame_result_t expected_frames[$];

    logic [31:0]        loop_len;
    logic [15:0]        speed_q88;
    logic               running;
    logic [31:0]        key_t[KEY_DEPTH];
    logic signed [31:0] key_v[KEY_DEPTH];
    int                 n_keys;
    logic [31:0]        ev_t[EVENT_DEPTH];
    int                 n_events;
    longint unsigned    key_clk;
    longint unsigned    ev_clk;
    int                 prev_key;
    bit                 prev_key_ok;
    int                 prev_ev;
    bit                 prev_ev_ok;

    function automatic longint unsigned clock_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > CLOCK_SAT) ? CLOCK_SAT : s;
    endfunction

    task automatic interpolate_item(input logic [FUNC_W-1:0] f, input logic [MS_W-1:0] ms,
                                    input logic [31:0] et, input logic signed [31:0] ev);
        frame_result_t   r;
        longint unsigned delta;
        longint unsigned lp;
        longint unsigned t;
        longint unsigned t1;
        longint unsigned t2;
        longint unsigned num;
        longint unsigned den;
        longint          frac;
        longint          diff;
        longint          v;
        int              i;
        int              k1;
        int              k2;
        int              p;
        r = '0;
        case (f)
            FN_TICK:
            begin
                if (!running)
                begin
                    r.status = STAT_DIS;
                end
                else
                begin
                    delta = longint'(ms) * longint'(speed_q88);
                    key_clk = clock_add(key_clk, delta);
                    ev_clk = clock_add(ev_clk, delta);
                    if (loop_len == 0)
                    begin
                        r.status = STAT_ZERO;
                    end
                    else if (n_keys > 0)
                    begin
                        lp = loop_len;
                        t = key_clk;
                        if (t > lp) t = ((t - 1) % lp) + 1;
                        i = 0;
                        while (i < n_keys && longint'(key_t[i]) < t) i++;
                        if (i == n_keys)
                        begin
                            k2 = 0;
                            t2 = lp + key_t[0];
                            k1 = n_keys - 1;
                        end
                        else
                        begin
                            k2 = i;
                            t2 = key_t[i];
                            k1 = (i != 0 && t < key_t[i]) ? i - 1 : i;
                        end
                        t1 = key_t[k1];
                        if (t1 == t2 || t < t1)
                        begin
                            v = key_v[k1];
                        end
                        else
                        begin
                            num = t - t1;
                            den = t2 - t1;
                            if (num > den) num = den;
                            frac = longint'((num << 16) / den);
                            diff = longint'(key_v[k2]) - longint'(key_v[k1]);
                            v = longint'(key_v[k1]) + ((diff * frac) >>> 16);
                        end
                        r.value = v[31:0];
                        r.value_valid = 1'b1;
                        r.key_index = k1[KEY_IDX_W-1:0];
                        if (!prev_key_ok || prev_key != k1)
                        begin
                            r.key_changed = 1'b1;
                            prev_key = k1;
                            prev_key_ok = 1'b1;
                        end
                    end
                    if (n_events > 0)
                    begin
                        i = 0;
                        while (i < n_events && longint'(ev_t[i]) < ev_clk) i++;
                        if (i == n_events) i = n_events - 1;
                        else if (i != 0 && ev_clk < ev_t[i]) i--;
                        r.event_index = i[EV_IDX_W-1:0];
                        if (!prev_ev_ok || prev_ev != i)
                        begin
                            r.event_fired = 1'b1;
                            prev_ev = i;
                            prev_ev_ok = 1'b1;
                        end
                    end
                end
            end
            FN_ADDK:
            begin
                if (n_keys >= KEY_DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    p = 0;
                    while (p < n_keys && key_t[p] <= et) p++;
                    for (i = n_keys; i > p; i--)
                    begin
                        key_t[i] = key_t[i-1];
                        key_v[i] = key_v[i-1];
                    end
                    key_t[p] = et;
                    key_v[p] = ev;
                    n_keys++;
                    if (prev_key_ok && p <= prev_key) prev_key++;
                end
            end
            FN_ADDE:
            begin
                if (n_events >= EVENT_DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    p = 0;
                    while (p < n_events && ev_t[p] <= et) p++;
                    for (i = n_events; i > p; i--) ev_t[i] = ev_t[i-1];
                    ev_t[p] = et;
                    n_events++;
                    if (prev_ev_ok && p <= prev_ev) prev_ev++;
                end
            end
            FN_CLRK:
            begin
                n_keys = 0;
                prev_key = 0;
                prev_key_ok = 1'b0;
            end
            FN_CLRE:
            begin
                n_events = 0;
                ev_clk = 0;
                prev_ev = 0;
                prev_ev_ok = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.clock_now = key_clk[CLK_W-1:0];
        expected_frames.push_back(r);
    endtask

    frame_result_t seen;
    frame_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_len = '0;
            speed_q88 = 16'd256;
            running = 1'b1;
            n_keys = 0;
            n_events = 0;
            key_clk = 0;
            ev_clk = 0;
            prev_key = 0;
            prev_key_ok = 1'b0;
            prev_ev = 0;
            prev_ev_ok = 1'b0;
            mismatches = 0;
            expected_frames.delete();
            awaiting = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOOP_LEN: loop_len = cfg_data;
                    REG_SPEED:    speed_q88 = cfg_data[15:0];
                    REG_ENABLED:  running = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen = '{status, clock_now, value, value_valid, key_index, key_changed,
                         event_index, event_fired};
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item: %p", seen);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, actual %p", want, seen);
                    end
                end
            end
            if (in_valid && !in_stall)
                interpolate_item(func, elapsed_ms, entry_time, entry_value);
            awaiting = expected_frames.size();
        end
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    import kfi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func;
    logic [MS_W-1:0]          elapsed_ms;
    logic [TIME_W-1:0]        entry_time;
    logic signed [VAL_W-1:0]  entry_value;
    logic                     out_valid;
    logic                     out_stall;
    logic [STAT_W-1:0]        status;
    logic [CLK_W-1:0]         clock_now;
    logic signed [VAL_W-1:0]  value;
    logic                     value_valid;
    logic [KEY_IDX_W-1:0]     key_index;
    logic                     key_changed;
    logic [EV_IDX_W-1:0]      event_index;
    logic                     event_fired;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DAT_W-1:0]     cfg_data;
    int                       mismatches;
    int                       awaiting;
    int                       send_idle_pct;
    int                       recv_stall_pct;
    int                       quiet_cycles;

    keyframe_interpolator i_dut (.*);

    kfi_checker i_checker (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [MS_W-1:0] ms,
                             input logic [31:0] et, input logic [31:0] ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        elapsed_ms <= ms;
        entry_time <= et;
        entry_value <= ev;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] len, input logic [15:0] spd, input logic en);
        wait_idle();
        write_reg(REG_LOOP_LEN, len);
        write_reg(REG_SPEED, {16'd0, spd});
        write_reg(REG_ENABLED, {31'd0, en});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_time(input logic [31:0] len);
        if ($urandom_range(9) == 0 || len == 0) return $urandom;
        return $urandom_range(0, len);
    endfunction

    task automatic random_scene(input int budget);
        int        n;
        int        r;
        logic [31:0] len;
        logic [15:0] spd;
        r = $urandom_range(19);
        len = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? 32'd1 :
              $urandom_range(256, 256 * 4000);
        r = $urandom_range(9);
        spd = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r < 6) ? 16'd256 : SPEED_W'($urandom);
        set_config(len, spd, $urandom_range(9) != 0);
        send_item(FN_CLRK, MS_W'($urandom), $urandom, $urandom);
        send_item(FN_CLRE, MS_W'($urandom), $urandom, $urandom);
        n = $urandom_range(0, 18);
        repeat (n) send_item(FN_ADDK, MS_W'($urandom), pick_time(len), $urandom);
        n = $urandom_range(0, 18);
        repeat (n) send_item(FN_ADDE, MS_W'($urandom), pick_time(len), $urandom);
        repeat (budget)
        begin
            r = $urandom_range(99);
            if (r < 80)
                send_item(FN_TICK, ($urandom_range(9) == 0) ? MS_W'($urandom)
                                                            : MS_W'($urandom_range(0, 300)),
                          $urandom, $urandom);
            else if (r < 88)
                send_item(FN_ADDK, MS_W'($urandom), pick_time(len), $urandom);
            else if (r < 94)
                send_item(FN_ADDE, MS_W'($urandom), pick_time(len), $urandom);
            else if (r < 96)
                send_item(FN_CLRK, MS_W'($urandom), $urandom, $urandom);
            else if (r < 98)
                send_item(FN_CLRE, MS_W'($urandom), $urandom, $urandom);
            else
                send_item(FUNC_W'($urandom_range(5, 7)), MS_W'($urandom), $urandom, $urandom);
        end
    endtask

    task automatic random_phase(input int items);
        int done_items;
        int chunk;
        done_items = 0;
        while (done_items < items)
        begin
            chunk = $urandom_range(20, 70);
            random_scene(chunk);
            done_items += chunk + 20;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_TICK;
        elapsed_ms = '0;
        entry_time = '0;
        entry_value = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_LOOP_LEN;
        cfg_data = '0;
        send_idle_pct = 24;
        recv_stall_pct = 81;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FN_TICK, 16'd100, 32'd0, 32'd0);
        send_item(FN_ADDK, 16'd0, 32'd0, 32'h7FFF_FFFF);
        send_item(FN_TICK, 16'd10, 32'd0, 32'd0);
        set_config(32'd256000, 16'd256, 1'b1);
        send_item(FN_TICK, 16'd0, 32'd0, 32'd0);
        send_item(FN_ADDK, 16'd0, 32'd128000, 32'h8000_0000);
        send_item(FN_ADDK, 16'd0, 32'd128000, 32'h0001_0000);
        send_item(FN_ADDK, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FN_ADDE, 16'd0, 32'd0, 32'd0);
        send_item(FN_ADDE, 16'd0, 32'd64000, 32'd0);
        send_item(FN_ADDE, 16'd0, 32'd64000, 32'd0);
        send_item(FN_TICK, 16'd250, 32'd0, 32'd0);
        send_item(FN_TICK, 16'd250, 32'd0, 32'd0);
        send_item(FN_TICK, 16'hFFFF, 32'd0, 32'd0);
        send_item(FN_ADDK, 16'd0, 32'd0, 32'd5);
        send_item(FN_TICK, 16'd1, 32'd0, 32'd0);
        send_item(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(3'd6, 16'd0, 32'd0, 32'd0);
        send_item(3'd7, 16'd0, 32'd0, 32'd0);
        set_config(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_item(FN_TICK, 16'd500, 32'd0, 32'd0);
        set_config(32'd1, 16'd0, 1'b1);
        send_item(FN_TICK, 16'd500, 32'd0, 32'd0);
        repeat (18) send_item(FN_ADDK, 16'd0, $urandom, $urandom);
        repeat (18) send_item(FN_ADDE, 16'd0, $urandom, $urandom);
        send_item(FN_TICK, 16'd3, 32'd0, 32'd0);
        send_item(FN_CLRE, 16'd0, 32'd0, 32'd0);
        send_item(FN_CLRK, 16'd0, 32'd0, 32'd0);
        send_item(FN_TICK, 16'd3, 32'd0, 32'd0);

        random_phase(500);
        wait_idle();
        send_idle_pct = 81;
        recv_stall_pct = 24;
        random_phase(500);
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(500);

        in_valid <= 1'b0;
        while (awaiting != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/kfi_pkg.sv
hw/rtl/kfi_serdiv.sv
hw/rtl/keyframe_interpolator.sv
tb/kfi_checker.sv
tb/tb_top.sv
